// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the one-wire bus master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define OW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one-wire check failed: implication");

// Next-cycle implication, disabled while reset is high
`define OW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("one-wire check failed: next cycle");

// Next-cycle implication that also holds across reset
`define OW_ASSERT_NEXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("one-wire check failed: reset behavior");

`endif

// ===== rtl/ow_pkg.sv =====
// ----------------------------------------------------------------------------
// ow_pkg
// Shared types and codes of the one-wire bus master.
// ----------------------------------------------------------------------------
package ow_pkg;

  // Request codes carried on the action field
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_RESET = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_TEMP  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [2:0] REG_PRES_WAIT     = 3'd2;
  localparam logic [2:0] REG_PRES_LOW      = 3'd3;
  localparam logic [2:0] REG_WRITE_ONE     = 3'd4;
  localparam logic [2:0] REG_WRITE_ZERO    = 3'd5;
  localparam logic [2:0] REG_READ_LOW      = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // Bus commands
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // Fixed slot timings, already reduced by one tick
  localparam logic [9:0] WRITE_ONE_REC_SPAN  = 10'd57;
  localparam logic [9:0] WRITE_ZERO_REC_SPAN = 10'd1;
  localparam logic [9:0] READ_REC_SPAN       = 10'd43;

  // Sequence steps
  localparam logic [3:0] STEP_LSB_READ = 4'd6;
  localparam logic [3:0] STEP_LAST     = 4'd7;
  localparam logic [3:0] STEP_SINGLE   = 4'd8;

  // Bus phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RST_LOW   = 4'd1;
  localparam logic [3:0] PH_RST_REL   = 4'd2;
  localparam logic [3:0] PH_PRES_WAIT = 4'd3;
  localparam logic [3:0] PH_PRES_LOW  = 4'd4;
  localparam logic [3:0] PH_W_LOW     = 4'd5;
  localparam logic [3:0] PH_W_REC     = 4'd6;
  localparam logic [3:0] PH_R_LOW     = 4'd7;
  localparam logic [3:0] PH_R_SAMP    = 4'd8;
  localparam logic [3:0] PH_R_REC     = 4'd9;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [5:0] reset_release_time;
    logic [7:0] presence_wait_limit;
    logic [8:0] presence_low_limit;
    logic [3:0] write_one_low_time;
    logic [6:0] write_zero_low_time;
    logic [3:0] read_low_time;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence_failed;
    logic [7:0]        byte_in;
    logic signed [15:0] temperature;
  } result_t;

endpackage

// ===== rtl/ow_cfg.sv =====
// ----------------------------------------------------------------------------
// ow_cfg
// Configuration register file of the one-wire bus master.
// ----------------------------------------------------------------------------
module ow_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ow_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ow_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ow_pkg::cfg_t                  cfg
);
  import ow_pkg::*;

  // Take every write at once
  assign cfg_ready = 1'b1;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time      <= 10'd750;
      cfg.reset_release_time  <= 6'd15;
      cfg.presence_wait_limit <= 8'd100;
      cfg.presence_low_limit  <= 9'd240;
      cfg.write_one_low_time  <= 4'd8;
      cfg.write_zero_low_time <= 7'd70;
      cfg.read_low_time       <= 4'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESET_LOW:     cfg.reset_low_time      <= cfg_data[9:0];
        REG_RESET_RELEASE: cfg.reset_release_time  <= cfg_data[5:0];
        REG_PRES_WAIT:     cfg.presence_wait_limit <= cfg_data[7:0];
        REG_PRES_LOW:      cfg.presence_low_limit  <= cfg_data[8:0];
        REG_WRITE_ONE:     cfg.write_one_low_time  <= cfg_data[3:0];
        REG_WRITE_ZERO:    cfg.write_zero_low_time <= cfg_data[6:0];
        REG_READ_LOW:      cfg.read_low_time       <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/ow_engine.sv =====
// ----------------------------------------------------------------------------
// ow_engine
// Bus phase sequencer: advances one tick per accepted transaction and
// forms the result of that tick.
// ----------------------------------------------------------------------------
module ow_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [2:0]      action,
  input  logic [7:0]      byte_out,
  input  logic            line_level,
  input  ow_pkg::cfg_t    cfg,
  output ow_pkg::result_t result
);
  import ow_pkg::*;

  // State registers
  logic [3:0]  phase, phase_next;
  logic [9:0]  slot_timer, slot_timer_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  sequence_step, sequence_step_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [15:0] temperature_hold, temperature_hold_next;
  logic        presence_flag, presence_flag_next;
  logic [7:0]  read_hold, read_hold_next;

  logic        done_now;
  logic        finish;
  logic        active;
  logic [9:0]  timer_inc;
  logic [3:0]  step_inc;
  logic [7:0]  shifted;

  // One tick less than a duration, zero stays zero
  function automatic logic [9:0] span(input logic [9:0] v);
    return (v == 10'd0) ? 10'd0 : v - 10'd1;
  endfunction

  function automatic logic [9:0] write_span(input logic b, input cfg_t c);
    return b ? span({6'd0, c.write_one_low_time}) : span({3'd0, c.write_zero_low_time});
  endfunction

  assign timer_inc = slot_timer + 10'd1;
  assign step_inc  = sequence_step + 4'd1;
  assign shifted   = {1'b0, shift_byte[7:1]};
  assign active    = (slot_timer != 10'd0) && (phase != PH_PRES_WAIT) &&
                     (phase != PH_PRES_LOW) && (phase != PH_R_SAMP) && (phase != PH_IDLE);

  // Advance the bus phase by one tick
  always_comb begin
    phase_next            = phase;
    slot_timer_next       = slot_timer;
    bit_count_next        = bit_count;
    shift_byte_next       = shift_byte;
    sequence_step_next    = sequence_step;
    low_byte_hold_next    = low_byte_hold;
    temperature_hold_next = temperature_hold;
    presence_flag_next    = presence_flag;
    read_hold_next        = read_hold;
    done_now              = 1'b0;
    finish                = 1'b0;

    if (active) begin
      slot_timer_next = slot_timer - 10'd1;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          priority if (action == ACT_RESET) begin
            sequence_step_next = STEP_SINGLE;
            phase_next         = PH_RST_LOW;
            slot_timer_next    = span(cfg.reset_low_time);
          end else if (action == ACT_WRITE) begin
            sequence_step_next = STEP_SINGLE;
            shift_byte_next    = byte_out;
            bit_count_next     = 3'd0;
            phase_next         = PH_W_LOW;
            slot_timer_next    = write_span(byte_out[0], cfg);
          end else if (action == ACT_READ) begin
            sequence_step_next = STEP_SINGLE;
            shift_byte_next    = 8'd0;
            bit_count_next     = 3'd0;
            phase_next         = PH_R_LOW;
            slot_timer_next    = span({6'd0, cfg.read_low_time});
          end else if (action == ACT_TEMP) begin
            sequence_step_next = 4'd0;
            phase_next         = PH_RST_LOW;
            slot_timer_next    = span(cfg.reset_low_time);
          end else begin
          end
        end
        PH_RST_LOW: begin
          phase_next      = PH_RST_REL;
          slot_timer_next = span({4'd0, cfg.reset_release_time});
        end
        PH_RST_REL: begin
          phase_next      = PH_PRES_WAIT;
          slot_timer_next = 10'd0;
        end
        PH_PRES_WAIT: begin
          if (line_level) begin
            slot_timer_next = timer_inc;
            if (timer_inc >= {2'd0, cfg.presence_wait_limit}) begin
              presence_flag_next = 1'b1;
              finish             = 1'b1;
            end
          end else begin
            slot_timer_next = 10'd1;
            phase_next      = PH_PRES_LOW;
            if (10'd1 >= {1'b0, cfg.presence_low_limit}) begin
              presence_flag_next = 1'b1;
              finish             = 1'b1;
            end
          end
        end
        PH_PRES_LOW: begin
          if (line_level) begin
            presence_flag_next = 1'b0;
            finish             = 1'b1;
          end else begin
            slot_timer_next = timer_inc;
            if (timer_inc >= {1'b0, cfg.presence_low_limit}) begin
              presence_flag_next = 1'b1;
              finish             = 1'b1;
            end
          end
        end
        PH_W_LOW: begin
          phase_next      = PH_W_REC;
          slot_timer_next = shift_byte[0] ? WRITE_ONE_REC_SPAN : WRITE_ZERO_REC_SPAN;
        end
        PH_W_REC: begin
          shift_byte_next = shifted;
          if (bit_count == 3'd7) begin
            finish = 1'b1;
          end else begin
            bit_count_next  = bit_count + 3'd1;
            phase_next      = PH_W_LOW;
            slot_timer_next = write_span(shifted[0], cfg);
          end
        end
        PH_R_LOW: begin
          phase_next      = PH_R_SAMP;
          slot_timer_next = 10'd0;
        end
        PH_R_SAMP: begin
          shift_byte_next = {line_level, shift_byte[7:1]};
          phase_next      = PH_R_REC;
          slot_timer_next = READ_REC_SPAN;
        end
        PH_R_REC: begin
          if (bit_count == 3'd7) begin
            read_hold_next = shift_byte;
            if (sequence_step == STEP_LSB_READ) begin
              low_byte_hold_next = shift_byte;
            end else if (sequence_step == STEP_LAST) begin
              temperature_hold_next = {shift_byte, low_byte_hold};
            end
            finish = 1'b1;
          end else begin
            bit_count_next  = bit_count + 3'd1;
            phase_next      = PH_R_LOW;
            slot_timer_next = span({6'd0, cfg.read_low_time});
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          slot_timer_next = 10'd0;
        end
      endcase
    end

    // End of one bus operation: stop, or launch the next sequence step
    if (finish) begin
      if (sequence_step >= STEP_LAST) begin
        phase_next      = PH_IDLE;
        slot_timer_next = 10'd0;
        done_now        = 1'b1;
      end else begin
        sequence_step_next = step_inc;
        unique case (step_inc)
          4'd0, 4'd3: begin
            phase_next      = PH_RST_LOW;
            slot_timer_next = span(cfg.reset_low_time);
          end
          4'd1, 4'd4, 4'd2, 4'd5: begin
            priority if (step_inc == 4'd2) begin
              shift_byte_next = CMD_CONVERT;
            end else if (step_inc == 4'd5) begin
              shift_byte_next = CMD_READ_PAD;
            end else begin
              shift_byte_next = CMD_SKIP_ROM;
            end
            bit_count_next  = 3'd0;
            phase_next      = PH_W_LOW;
            slot_timer_next = write_span(shift_byte_next[0], cfg);
          end
          default: begin
            shift_byte_next = 8'd0;
            bit_count_next  = 3'd0;
            phase_next      = PH_R_LOW;
            slot_timer_next = span({6'd0, cfg.read_low_time});
          end
        endcase
      end
    end
  end

  // Form the result of this tick from the state it leaves behind
  always_comb begin
    result.drive_low       = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW) ||
                             (phase_next == PH_R_LOW);
    result.busy_res        = (phase_next != PH_IDLE);
    result.done_res        = done_now;
    result.presence_failed = presence_flag_next;
    result.byte_in         = read_hold_next;
    result.temperature     = temperature_hold_next;
  end

  // Update state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      slot_timer       <= 10'd0;
      bit_count        <= 3'd0;
      shift_byte       <= 8'd0;
      sequence_step    <= 4'd0;
      low_byte_hold    <= 8'd0;
      temperature_hold <= 16'd0;
      presence_flag    <= 1'b0;
      read_hold        <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      slot_timer       <= slot_timer_next;
      bit_count        <= bit_count_next;
      shift_byte       <= shift_byte_next;
      sequence_step    <= sequence_step_next;
      low_byte_hold    <= low_byte_hold_next;
      temperature_hold <= temperature_hold_next;
      presence_flag    <= presence_flag_next;
      read_hold        <= read_hold_next;
    end
  end

endmodule

// ===== rtl/ow_out_buf.sv =====
// ----------------------------------------------------------------------------
// ow_out_buf
// Output register with a skid stage: results wait here while the
// downstream side stalls, and input keeps flowing until both are full.
// ----------------------------------------------------------------------------
module ow_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ow_pkg::result_t load_data,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output ow_pkg::result_t out_data
);
  import ow_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign can_load = !skid_valid;

  // Hold results; refill the output register from the skid stage first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (load) begin
        out_data <= load_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (load) begin
        out_data  <= load_data;
        out_valid <= 1'b1;
      end
    end else if (load) begin
      skid_data  <= load_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ===== rtl/one_wire_temp_sensor_master.sv =====
// A result is registered in the output buffer when its input transaction is accepted.
// Throughput: one input transaction per cycle while in_ready is high; one result per input.
// A two-entry output buffer lets input continue while one result waits.
// Reset (rst, synchronous): bus idle, all holds zero, configuration at defaults.
// ----------------------------------------------------------------------------
// one_wire_temp_sensor_master
// One-wire bus master stepped one microsecond tick per input transaction.
// ----------------------------------------------------------------------------
module one_wire_temp_sensor_master (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     action,
  input  logic [7:0]                     byte_out,
  input  logic                           line_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           drive_low,
  output logic                           busy_res,
  output logic                           done_res,
  output logic                           presence_failed,
  output logic [7:0]                     byte_in,
  output logic signed [15:0]             temperature,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ow_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ow_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ow_pkg::*;

  cfg_t    cfg;
  result_t step_result;
  result_t out_data;
  logic    step;

  assign step = in_valid && in_ready;

  ow_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ow_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .action     (action),
    .byte_out   (byte_out),
    .line_level (line_level),
    .cfg        (cfg),
    .result     (step_result)
  );

  ow_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .load_data (step_result),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Unpack the result onto the output ports
  assign drive_low       = out_data.drive_low;
  assign busy_res        = out_data.busy_res;
  assign done_res        = out_data.done_res;
  assign presence_failed = out_data.presence_failed;
  assign byte_in         = out_data.byte_in;
  assign temperature     = out_data.temperature;

endmodule

// ===== rtl/ow_checker.sv =====
// ----------------------------------------------------------------------------
// ow_checker
// Port-level checks of the one-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ow_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               drive_low,
  input logic               busy_res,
  input logic               done_res,
  input logic [7:0]         byte_in,
  input logic signed [15:0] temperature
);

  // Bus is only pulled low while a request runs
  `OW_ASSERT_IMP(a_drive_busy, clk, rst, out_valid && drive_low, busy_res)

  // Completion is reported on the tick the block goes idle
  `OW_ASSERT_IMP(a_done_idle, clk, rst, out_valid && done_res, !busy_res)

  // Input only stalls while a result is waiting at the output
  `OW_ASSERT_IMP(a_full_has_output, clk, rst, !in_ready, out_valid)

  // A stalled result holds its value
  `OW_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(temperature) && $stable(byte_in))

  // Reset empties the output
  `OW_ASSERT_NEXT_RST(a_reset_empty, clk, rst, !out_valid)

endmodule

bind one_wire_temp_sensor_master ow_checker u_ow_checker (.*);
